[src/ssdc_pkg.sv]
// ssdc_pkg: shared types and constants for the servo stiction duty calibrator
// no dependencies
package ssdc_pkg;

    localparam int unsigned SAMPLE_INTERVAL_MS = 100;
    localparam int unsigned TIMEOUT_MS         = 30000;
    localparam int unsigned MAX_ITERATIONS     = 100;
    localparam int unsigned BREAK_SAMPLE_CAP   = 6;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_DUTY = 3'd0,
        CFG_STOP_DUTY  = 3'd1,
        CFG_STEP_DUTY  = 3'd2,
        CFG_MIN_COUNTS = 3'd3,
        CFG_MIN_SPEED  = 3'd4,
        CFG_REQ_MOVING = 3'd5,
        CFG_SETTLE_MS  = 3'd6,
        CFG_KICK_MS    = 3'd7
    } cfg_idx_t;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BREAK = 2'd1,
        PH_HOLD  = 2'd2,
        PH_DONE  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [9:0]  start_duty;
        logic [9:0]  stop_duty;
        logic [9:0]  step_duty;
        logic [15:0] min_counts;
        logic [15:0] min_speed;
        logic [7:0]  required_moving;
        logic [15:0] settle_ms;
        logic [15:0] kick_ms;
    } cfg_t;

    typedef struct packed {
        logic        action;
        logic [31:0] now_ms;
        logic [31:0] encoder_count;
    } item_t;

    typedef struct packed {
        logic [10:0] drive_duty;
        logic [1:0]  phase;
        logic        timed_out;
        logic [9:0]  fwd_break_duty;
        logic [9:0]  fwd_hold_duty;
        logic [9:0]  rev_break_duty;
        logic [9:0]  rev_hold_duty;
        logic        going_forward;
    } result_t;

endpackage

[src/ssdc_cfg_regs.sv]
// ssdc_cfg_regs: configuration register file
// depends on ssdc_pkg
module ssdc_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               wr_en,
    input  logic [ssdc_pkg::CFG_IDX_W-1:0]     wr_idx,
    input  logic [ssdc_pkg::CFG_DATA_W-1:0]    wr_data,
    output ssdc_pkg::cfg_t                     cfg
);
    ssdc_pkg::cfg_t cfg_reg;
    assign cfg = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_duty      <= 10'd50;
            cfg_reg.stop_duty       <= 10'd1000;
            cfg_reg.step_duty       <= 10'd10;
            cfg_reg.min_counts      <= 16'd1;
            cfg_reg.min_speed       <= 16'd1;
            cfg_reg.required_moving <= 8'd3;
            cfg_reg.settle_ms       <= 16'd500;
            cfg_reg.kick_ms         <= 16'd100;
        end else if (wr_en) begin
            case (ssdc_pkg::cfg_idx_t'(wr_idx))
                ssdc_pkg::CFG_START_DUTY: cfg_reg.start_duty      <= wr_data[9:0];
                ssdc_pkg::CFG_STOP_DUTY:  cfg_reg.stop_duty       <= wr_data[9:0];
                ssdc_pkg::CFG_STEP_DUTY:  cfg_reg.step_duty       <= wr_data[9:0];
                ssdc_pkg::CFG_MIN_COUNTS: cfg_reg.min_counts      <= wr_data;
                ssdc_pkg::CFG_MIN_SPEED:  cfg_reg.min_speed       <= wr_data;
                ssdc_pkg::CFG_REQ_MOVING: cfg_reg.required_moving <= wr_data[7:0];
                ssdc_pkg::CFG_SETTLE_MS:  cfg_reg.settle_ms       <= wr_data;
                ssdc_pkg::CFG_KICK_MS:    cfg_reg.kick_ms         <= wr_data;
                default: ;
            endcase
        end
    end
endmodule

[src/ssdc_engine.sv]
// ssdc_engine: calibration state and per-item update, one registered pass
// depends on ssdc_pkg
module ssdc_engine #(
    parameter int unsigned SampleIntervalMs = ssdc_pkg::SAMPLE_INTERVAL_MS,
    parameter int unsigned TimeoutMs        = ssdc_pkg::TIMEOUT_MS,
    parameter int unsigned MaxIterations    = ssdc_pkg::MAX_ITERATIONS,
    parameter int unsigned BreakSampleCap   = ssdc_pkg::BREAK_SAMPLE_CAP
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_en,
    input  ssdc_pkg::item_t   item,
    input  ssdc_pkg::cfg_t    cfg,
    output ssdc_pkg::result_t result
);
    typedef enum logic [2:0] {
        MM_STOPPED, MM_SETTLING, MM_KICKING, MM_HOLDING, MM_STEADY
    } mode_t;

    ssdc_pkg::phase_t phase_reg, phase_next;
    mode_t       mode_reg, mode_next;
    logic        fwd_reg, fwd_next;
    logic [10:0] cand_reg, cand_next;
    logic [10:0] drive_reg, drive_next;
    logic [7:0]  iter_reg, iter_next, consec_reg, consec_next, samp_reg, samp_next;
    logic        found_reg, found_next, queued_reg, queued_next;
    logic        chkv_reg, chkv_next, tmo_reg, tmo_next;
    logic [31:0] mk_change_reg, mk_change_next, mk_settle_reg, mk_settle_next;
    logic [31:0] mk_kick_reg, mk_kick_next, mk_sample_reg, mk_sample_next;
    logic [31:0] mk_check_reg, mk_check_next;
    logic [31:0] lpos_reg, lpos_next, ldelta_reg, ldelta_next;
    logic [9:0]  res_reg [4];
    logic [9:0]  res_next [4];

    logic [31:0] now, enc;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] d);
        return d[31] ? (32'd0 - d) : d;
    endfunction

    always_comb begin
        logic [9:0]  mag;
        logic [31:0] el, d;
        logic        fast, moving, limit, done_step;
        logic [41:0] lhs;
        logic [47:0] rhs;
        logic [10:0] nxt_up;
        logic signed [11:0] nxt_dn;
        logic [1:0]  b;

        now = item.now_ms;
        enc = item.encoder_count;
        phase_next = phase_reg; mode_next = mode_reg; fwd_next = fwd_reg;
        cand_next = cand_reg; drive_next = drive_reg; iter_next = iter_reg;
        consec_next = consec_reg; samp_next = samp_reg; found_next = found_reg;
        queued_next = queued_reg; chkv_next = chkv_reg; tmo_next = tmo_reg;
        mk_change_next = mk_change_reg; mk_settle_next = mk_settle_reg;
        mk_kick_next = mk_kick_reg; mk_sample_next = mk_sample_reg;
        mk_check_next = mk_check_reg; lpos_next = lpos_reg; ldelta_next = ldelta_reg;
        for (int i = 0; i < 4; i++) res_next[i] = res_reg[i];
        mag = '0; el = '0; d = '0; fast = 1'b0; moving = 1'b0; limit = 1'b0;
        done_step = 1'b0; lhs = '0; rhs = '0; nxt_up = '0; nxt_dn = '0;
        b = fwd_reg ? 2'd0 : 2'd2;

        // measurement, used in settling and holding
        if (!chkv_reg) begin
            d = 32'd0;
        end else begin
            el = now - mk_check_reg;
            d = enc - lpos_reg;
        end
        lhs = 42'(mag32(d)) * 42'd1000;
        rhs = 48'(cfg.min_speed) * 48'(el);
        fast = chkv_reg && (el != 32'd0) && (48'(lhs) > rhs);

        if (item.action) begin
            for (int i = 0; i < 4; i++) res_next[i] = '0;
            tmo_next = 1'b0; fwd_next = 1'b1; phase_next = ssdc_pkg::PH_BREAK;
            iter_next = '0; found_next = 1'b0; cand_next = {1'b0, cfg.start_duty};
            queued_next = 1'b1; drive_next = '0; mk_change_next = now;
            mk_settle_next = now; mode_next = MM_SETTLING;
        end else if (phase_reg == ssdc_pkg::PH_BREAK || phase_reg == ssdc_pkg::PH_HOLD) begin
            // motor step
            case (mode_reg)
                MM_SETTLING: begin
                    if (!chkv_reg) begin
                        chkv_next = 1'b1; mk_check_next = now; lpos_next = enc;
                        ldelta_next = '0;
                    end else if (el != 32'd0) begin
                        lpos_next = enc; mk_check_next = now; ldelta_next = d;
                    end
                    if (now - mk_settle_reg >= 32'(cfg.settle_ms)) begin
                        mode_next = MM_STOPPED;
                        if (queued_reg) begin
                            queued_next = 1'b0;
                            mk_change_next = now; consec_next = '0; samp_next = '0;
                            if (phase_reg == ssdc_pkg::PH_BREAK) begin
                                mag = (cand_reg[9:0] > cfg.stop_duty) ? cfg.stop_duty
                                                                      : cand_reg[9:0];
                                mode_next = MM_HOLDING;
                            end else begin
                                mag = (res_reg[b] > cfg.stop_duty) ? cfg.stop_duty
                                                                  : res_reg[b];
                                mode_next = MM_KICKING; mk_kick_next = now;
                            end
                            drive_next = fwd_reg ? {1'b0, mag} : 11'(-{1'b0, mag});
                        end
                    end
                    mk_sample_next = now;
                end
                MM_KICKING: begin
                    if (now - mk_kick_reg >= 32'(cfg.kick_ms)) begin
                        mag = (cand_reg[9:0] > cfg.stop_duty) ? cfg.stop_duty
                                                              : cand_reg[9:0];
                        drive_next = fwd_reg ? {1'b0, mag} : 11'(-{1'b0, mag});
                        mode_next = MM_HOLDING; mk_sample_next = now;
                        consec_next = '0; samp_next = '0;
                    end
                end
                MM_HOLDING: begin
                    if (now - mk_sample_reg >= 32'(SampleIntervalMs)) begin
                        if (!chkv_reg) begin
                            chkv_next = 1'b1; mk_check_next = now; lpos_next = enc;
                            ldelta_next = '0;
                        end else if (el != 32'd0) begin
                            lpos_next = enc; mk_check_next = now; ldelta_next = d;
                        end
                        moving = fast && (mag32(ldelta_next) >= 32'(cfg.min_counts));
                        samp_next = sat_inc(samp_reg);
                        if (moving) begin
                            consec_next = sat_inc(consec_reg);
                            if (consec_next >= cfg.required_moving) mode_next = MM_STEADY;
                        end else begin
                            consec_next = '0;
                            if (phase_reg != ssdc_pkg::PH_BREAK
                                || samp_next >= 8'(BreakSampleCap))
                                mode_next = MM_STOPPED;
                        end
                        mk_sample_next = now;
                    end
                end
                default: ;
            endcase

            if (now - mk_change_next > 32'(TimeoutMs)) begin
                phase_next = ssdc_pkg::PH_IDLE; drive_next = '0;
                for (int i = 0; i < 4; i++) res_next[i] = '0;
                queued_next = 1'b0; tmo_next = 1'b1;
            end else if (mode_next == MM_STEADY || mode_next == MM_STOPPED) begin
                limit = iter_next >= 8'(MaxIterations);
                iter_next = sat_inc(iter_next);
                if (phase_reg == ssdc_pkg::PH_BREAK) begin
                    nxt_up = cand_next + {1'b0, cfg.step_duty};
                    if (limit || mode_next == MM_STEADY || nxt_up > {1'b0, cfg.stop_duty}) begin
                        if (!limit && mode_next == MM_STEADY) begin
                            found_next = 1'b1; res_next[b] = cand_next[9:0];
                        end else if (!found_next) begin
                            res_next[b] = cfg.stop_duty;
                        end
                        // to hold search
                        drive_next = '0; mk_settle_next = now; mode_next = MM_SETTLING;
                        phase_next = ssdc_pkg::PH_HOLD; iter_next = '0;
                        nxt_dn = $signed({2'b0, res_next[b]}) - $signed({2'b0, cfg.step_duty});
                        cand_next = (nxt_dn < $signed({2'b0, cfg.start_duty}))
                                    ? {1'b0, cfg.start_duty} : nxt_dn[10:0];
                        queued_next = 1'b1;
                    end else begin
                        cand_next = nxt_up; mk_sample_next = now; mk_change_next = now;
                        consec_next = '0; samp_next = '0;
                        mag = (nxt_up > {1'b0, cfg.stop_duty}) ? cfg.stop_duty : nxt_up[9:0];
                        drive_next = fwd_reg ? {1'b0, mag} : 11'(-{1'b0, mag});
                        mode_next = MM_HOLDING;
                    end
                end else begin
                    if (limit) begin
                        done_step = 1'b1;
                    end else if (mode_next == MM_STEADY) begin
                        nxt_dn = $signed({1'b0, cand_next}) - $signed({2'b0, cfg.step_duty});
                        res_next[b + 2'd1] = cand_next[9:0];
                        if (nxt_dn < $signed({2'b0, cfg.start_duty})) begin
                            done_step = 1'b1;
                        end else begin
                            cand_next = nxt_dn[10:0];
                            mag = (res_next[b] > cfg.stop_duty) ? cfg.stop_duty : res_next[b];
                            drive_next = fwd_reg ? {1'b0, mag} : 11'(-{1'b0, mag});
                            mode_next = MM_KICKING; mk_kick_next = now; mk_change_next = now;
                        end
                    end else begin
                        if (res_next[b + 2'd1] == '0) res_next[b + 2'd1] = res_next[b];
                        done_step = 1'b1;
                    end
                    if (done_step) begin
                        drive_next = '0; mk_settle_next = now; mode_next = MM_SETTLING;
                        if (fwd_reg) begin
                            fwd_next = 1'b0; phase_next = ssdc_pkg::PH_BREAK;
                            iter_next = '0; cand_next = {1'b0, cfg.start_duty};
                            found_next = 1'b0; queued_next = 1'b1;
                        end else begin
                            phase_next = ssdc_pkg::PH_DONE;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ssdc_pkg::PH_IDLE; mode_reg <= MM_STOPPED; fwd_reg <= 1'b1;
            cand_reg <= '0; drive_reg <= '0; iter_reg <= '0; consec_reg <= '0;
            samp_reg <= '0; found_reg <= 1'b0; queued_reg <= 1'b0; chkv_reg <= 1'b0;
            tmo_reg <= 1'b0; mk_change_reg <= '0; mk_settle_reg <= '0;
            mk_kick_reg <= '0; mk_sample_reg <= '0; mk_check_reg <= '0;
            lpos_reg <= '0; ldelta_reg <= '0;
            for (int i = 0; i < 4; i++) res_reg[i] <= '0;
        end else if (item_en) begin
            phase_reg <= phase_next; mode_reg <= mode_next; fwd_reg <= fwd_next;
            cand_reg <= cand_next; drive_reg <= drive_next; iter_reg <= iter_next;
            consec_reg <= consec_next; samp_reg <= samp_next; found_reg <= found_next;
            queued_reg <= queued_next; chkv_reg <= chkv_next; tmo_reg <= tmo_next;
            mk_change_reg <= mk_change_next; mk_settle_reg <= mk_settle_next;
            mk_kick_reg <= mk_kick_next; mk_sample_reg <= mk_sample_next;
            mk_check_reg <= mk_check_next; lpos_reg <= lpos_next;
            ldelta_reg <= ldelta_next;
            for (int i = 0; i < 4; i++) res_reg[i] <= res_next[i];
        end
    end

    always_comb begin
        result.drive_duty     = drive_next;
        result.phase          = phase_next;
        result.timed_out      = tmo_next;
        result.fwd_break_duty = res_next[0];
        result.fwd_hold_duty  = res_next[1];
        result.rev_break_duty = res_next[2];
        result.rev_hold_duty  = res_next[3];
        result.going_forward  = fwd_next;
    end
endmodule

[src/servo_stiction_duty_calibrator_core.sv]
// servo_stiction_duty_calibrator_core: top level of the stiction calibrator
// depends on ssdc_pkg, ssdc_cfg_regs, ssdc_engine
// result: each accepted word's result word is captured in the output register on accept
// throughput: one word per cycle while the output register is free or being drained;
// the single update pass sets the rate. reset: aresetn synchronous active low clears state, registers to defaults
module servo_stiction_duty_calibrator_core #(
    parameter int unsigned SampleIntervalMs = ssdc_pkg::SAMPLE_INTERVAL_MS,
    parameter int unsigned TimeoutMs        = ssdc_pkg::TIMEOUT_MS,
    parameter int unsigned MaxIterations    = ssdc_pkg::MAX_ITERATIONS,
    parameter int unsigned BreakSampleCap   = ssdc_pkg::BREAK_SAMPLE_CAP
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // now_ms[31:0], encoder_count[63:32]
    input  logic        s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // drive_duty, phase, timed_out, four duties, going_forward
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [ssdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssdc_pkg::CFG_DATA_W-1:0] cfg_data
);
    ssdc_pkg::cfg_t    cfg;
    ssdc_pkg::item_t   item;
    ssdc_pkg::result_t res;
    logic              accept;
    logic [63:0]       out_reg;
    logic              ovalid_reg;

    assign cfg_ready = 1'b1;
    // accept when output register free or being drained this cycle
    assign s_tready = !ovalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign item.action        = s_tuser;
    assign item.now_ms        = s_tdata[31:0];
    assign item.encoder_count = s_tdata[63:32];

    ssdc_cfg_regs u_cfg (
        .aclk(aclk), .aresetn(aresetn), .wr_en(cfg_valid), .wr_idx(cfg_index),
        .wr_data(cfg_data), .cfg(cfg)
    );

    ssdc_engine #(
        .SampleIntervalMs(SampleIntervalMs), .TimeoutMs(TimeoutMs),
        .MaxIterations(MaxIterations), .BreakSampleCap(BreakSampleCap)
    ) u_eng (
        .aclk(aclk), .aresetn(aresetn), .item_en(accept), .item(item), .cfg(cfg),
        .result(res)
    );

    // result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else if (accept) begin
            ovalid_reg <= 1'b1;
        end else if (m_tready) begin
            ovalid_reg <= 1'b0;
        end
        if (accept) begin
            out_reg <= {9'd0, res.going_forward, res.rev_hold_duty, res.rev_break_duty,
                        res.fwd_hold_duty, res.fwd_break_duty, res.timed_out, res.phase,
                        res.drive_duty};
        end
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = out_reg;
endmodule

[src/ssdc_checker.sv]
// ssdc_checker: port-level assertions for the calibrator top level
// depends on ssdc_pkg; bound to servo_stiction_duty_calibrator_core
module ssdc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata
);
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result lost");
    a_result_after_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid) else $error("no result word");
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready) else $error("stalled while empty");
    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[12:11] == ssdc_pkg::PH_IDLE |-> m_tdata[10:0] == 11'd0)
        else $error("drive while idle");
endmodule

bind servo_stiction_duty_calibrator_core ssdc_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

[bench/ssdc_scoreboard.sv]
// ssdc_scoreboard: watches the word, result and register channels of the stiction
// calibrator, predicts every result word and compares it field by field
// depends on ssdc_pkg
`timescale 1ns / 1ps

module ssdc_scoreboard
    import ssdc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    typedef enum logic [2:0] {
        MOT_STOPPED, MOT_SETTLING, MOT_KICKING, MOT_HOLDING, MOT_STEADY
    } motor_t;

    typedef struct packed {
        logic [10:0] drive;
        logic [1:0]  phase;
        logic        timed_out;
        logic [9:0]  fb, fh, rb, rh;
        logic        fwd;
    } word_t;

    logic [9:0]  k_start, k_stop, k_step;
    logic [15:0] k_min_counts, k_min_speed, k_settle, k_kick;
    logic [7:0]  k_req;

    phase_t      ph;
    motor_t      mot;
    bit          fwd, found, queued, meas_ok, timed;
    int          cand, drive;
    int unsigned iter, consec, samples;
    logic [31:0] t_change, t_settle, t_kick, t_sample, t_meas;
    logic [31:0] last_pos, last_delta, cur_now, cur_enc;
    int unsigned duty [4];
    word_t       wanted_words[$];

    function automatic logic [31:0] mag(logic [31:0] d);
        return d[31] ? (32'd0 - d) : d;
    endfunction

    function automatic int unsigned bump(int unsigned v);
        return (v < 255) ? v + 1 : 255;
    endfunction

    function automatic int base_slot();
        return fwd ? 0 : 2;
    endfunction

    function automatic void set_drive(int unsigned m);
        if (m > k_stop) m = k_stop;
        drive = fwd ? int'(m) : -int'(m);
    endfunction

    function automatic void begin_settle();
        t_settle = cur_now;
        mot = MOT_SETTLING;
    endfunction

    // speed test done by multiplication: |d|*1000 > min_speed*elapsed
    function automatic bit measure_fast();
        logic [31:0] el, d;
        if (!meas_ok) begin
            meas_ok = 1;
            t_meas = cur_now;
            last_pos = cur_enc;
            last_delta = 0;
            return 0;
        end
        el = cur_now - t_meas;
        if (el == 0) return 0;
        d = cur_enc - last_pos;
        last_pos = cur_enc;
        t_meas = cur_now;
        last_delta = d;
        return ({32'd0, mag(d)} * 64'd1000) > ({48'd0, k_min_speed} * {32'd0, el});
    endfunction

    function automatic void begin_test(int d);
        cand = d;
        t_sample = cur_now;
        t_change = cur_now;
        consec = 0;
        samples = 0;
        if (ph == PH_BREAK) begin
            set_drive(d);
            mot = MOT_HOLDING;
        end else begin
            set_drive(duty[base_slot()]);
            mot = MOT_KICKING;
            t_kick = cur_now;
        end
    endfunction

    function automatic void enter_hold();
        int c;
        c = int'(duty[base_slot()]) - int'(k_step);
        drive = 0;
        begin_settle();
        ph = PH_HOLD;
        iter = 0;
        if (c < int'(k_start)) c = k_start;
        cand = c;
        queued = 1;
    endfunction

    function automatic void end_hold();
        drive = 0;
        begin_settle();
        if (fwd) begin
            fwd = 0;
            ph = PH_BREAK;
            iter = 0;
            cand = k_start;
            found = 0;
            queued = 1;
        end else begin
            ph = PH_DONE;
        end
    endfunction

    function automatic void resolve_break();
        int b;
        bit lim;
        int nxt;
        b = base_slot();
        lim = iter >= MAX_ITERATIONS;
        iter = bump(iter);
        if (lim) begin
            if (!found) duty[b] = k_stop;
            enter_hold();
        end else if (mot == MOT_STEADY) begin
            found = 1;
            duty[b] = cand;
            enter_hold();
        end else begin
            nxt = cand + int'(k_step);
            if (nxt > int'(k_stop)) begin
                if (!found) duty[b] = k_stop;
                enter_hold();
            end else begin
                begin_test(nxt);
            end
        end
    endfunction

    function automatic void resolve_hold();
        int b;
        bit lim;
        int nxt;
        b = base_slot();
        lim = iter >= MAX_ITERATIONS;
        iter = bump(iter);
        if (lim) begin
            end_hold();
        end else if (mot == MOT_STEADY) begin
            nxt = cand - int'(k_step);
            duty[b+1] = cand;
            if (nxt < int'(k_start)) begin
                end_hold();
            end else begin
                cand = nxt;
                set_drive(duty[b]);
                mot = MOT_KICKING;
                t_kick = cur_now;
                t_change = cur_now;
            end
        end else begin
            if (duty[b+1] == 0) duty[b+1] = duty[b];
            end_hold();
        end
    endfunction

    function automatic void advance_motor();
        bit fast, moving;
        case (mot)
            MOT_SETTLING: begin
                fast = measure_fast();
                if (cur_now - t_settle >= k_settle) begin
                    mot = MOT_STOPPED;
                    if (queued) begin
                        queued = 0;
                        begin_test(cand);
                    end
                end
                t_sample = cur_now;
            end
            MOT_KICKING: begin
                if (cur_now - t_kick >= k_kick) begin
                    set_drive(cand);
                    mot = MOT_HOLDING;
                    t_sample = cur_now;
                    consec = 0;
                    samples = 0;
                end
            end
            MOT_HOLDING: begin
                if (cur_now - t_sample >= SAMPLE_INTERVAL_MS) begin
                    fast = measure_fast();
                    moving = fast && (mag(last_delta) >= k_min_counts);
                    samples = bump(samples);
                    if (moving) begin
                        consec = bump(consec);
                        if (consec >= k_req) mot = MOT_STEADY;
                    end else begin
                        consec = 0;
                        if (ph != PH_BREAK || samples >= BREAK_SAMPLE_CAP) mot = MOT_STOPPED;
                    end
                    t_sample = cur_now;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic word_t calibrate_word(bit start, logic [31:0] now_ms, logic [31:0] enc);
        word_t w;
        logic [31:0] dr;
        cur_now = now_ms;
        cur_enc = enc;
        if (start) begin
            foreach (duty[i]) duty[i] = 0;
            timed = 0;
            fwd = 1;
            ph = PH_BREAK;
            iter = 0;
            found = 0;
            cand = k_start;
            queued = 1;
            drive = 0;
            t_change = cur_now;
            begin_settle();
        end else if (ph == PH_BREAK || ph == PH_HOLD) begin
            advance_motor();
            if (cur_now - t_change > TIMEOUT_MS) begin
                ph = PH_IDLE;
                drive = 0;
                foreach (duty[i]) duty[i] = 0;
                queued = 0;
                timed = 1;
            end else if (mot == MOT_STEADY || mot == MOT_STOPPED) begin
                if (ph == PH_BREAK) resolve_break();
                else resolve_hold();
            end
        end
        dr = drive;
        w.drive = dr[10:0];
        w.phase = ph;
        w.timed_out = timed;
        w.fb = duty[0][9:0];
        w.fh = duty[1][9:0];
        w.rb = duty[2][9:0];
        w.rh = duty[3][9:0];
        w.fwd = fwd;
        return w;
    endfunction

    function automatic void clear_state();
        k_start = 50; k_stop = 1000; k_step = 10; k_min_counts = 1; k_min_speed = 1;
        k_req = 3; k_settle = 500; k_kick = 100;
        ph = PH_IDLE; mot = MOT_STOPPED; fwd = 1; cand = 0; drive = 0;
        iter = 0; consec = 0; samples = 0;
        found = 0; queued = 0; meas_ok = 0; timed = 0;
        t_change = 0; t_settle = 0; t_kick = 0; t_sample = 0; t_meas = 0;
        last_pos = 0; last_delta = 0;
        foreach (duty[i]) duty[i] = 0;
    endfunction

    assign pending = wanted_words.size();

    initial fail_count = 0;

    always @(posedge aclk) begin
        word_t w, got;
        if (!aresetn) begin
            clear_state();
            wanted_words.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_START_DUTY: k_start = cfg_data[9:0];
                    CFG_STOP_DUTY:  k_stop = cfg_data[9:0];
                    CFG_STEP_DUTY:  k_step = cfg_data[9:0];
                    CFG_MIN_COUNTS: k_min_counts = cfg_data;
                    CFG_MIN_SPEED:  k_min_speed = cfg_data;
                    CFG_REQ_MOVING: k_req = cfg_data[7:0];
                    CFG_SETTLE_MS:  k_settle = cfg_data;
                    CFG_KICK_MS:    k_kick = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got.drive = m_tdata[10:0];
                got.phase = m_tdata[12:11];
                got.timed_out = m_tdata[13];
                got.fb = m_tdata[23:14];
                got.fh = m_tdata[33:24];
                got.rb = m_tdata[43:34];
                got.rh = m_tdata[53:44];
                got.fwd = m_tdata[54];
                if (wanted_words.size() == 0) begin
                    $error("result word with nothing expected: %h", m_tdata);
                    fail_count++;
                end else begin
                    w = wanted_words.pop_front();
                    if (got.drive !== w.drive) begin
                        $error("drive_duty expected %0d got %0d", $signed(w.drive), $signed(got.drive));
                        fail_count++;
                    end
                    if (got.phase !== w.phase) begin
                        $error("phase expected %0d got %0d", w.phase, got.phase);
                        fail_count++;
                    end
                    if (got.timed_out !== w.timed_out) begin
                        $error("timed_out expected %0d got %0d", w.timed_out, got.timed_out);
                        fail_count++;
                    end
                    if (got.fb !== w.fb) begin
                        $error("fwd_break_duty expected %0d got %0d", w.fb, got.fb);
                        fail_count++;
                    end
                    if (got.fh !== w.fh) begin
                        $error("fwd_hold_duty expected %0d got %0d", w.fh, got.fh);
                        fail_count++;
                    end
                    if (got.rb !== w.rb) begin
                        $error("rev_break_duty expected %0d got %0d", w.rb, got.rb);
                        fail_count++;
                    end
                    if (got.rh !== w.rh) begin
                        $error("rev_hold_duty expected %0d got %0d", w.rh, got.rh);
                        fail_count++;
                    end
                    if (got.fwd !== w.fwd) begin
                        $error("going_forward expected %0d got %0d", w.fwd, got.fwd);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                wanted_words.push_back(calibrate_word(s_tuser, s_tdata[31:0], s_tdata[63:32]));
        end
    end

endmodule

[bench/servo_stiction_duty_calibrator_core_tb.sv]
// servo_stiction_duty_calibrator_core_tb: drives calibration runs against a crude
// motor that moves once the drive passes a threshold, under several idling mixes
// depends on ssdc_pkg, servo_stiction_duty_calibrator_core, ssdc_scoreboard
`timescale 1ns / 1ps

module servo_stiction_duty_calibrator_core_tb;
    import ssdc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int WORD_TARGET = 950;

    logic        aclk = 0;
    logic        aresetn;
    logic        s_tvalid, s_tready, s_tuser;
    logic [63:0] s_tdata;       // now_ms[31:0], encoder_count[63:32]
    logic        m_tvalid, m_tready;
    logic [63:0] m_tdata;       // drive_duty, phase, timed_out, four duties, going_forward
    logic        cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count, pending;
    int cycles = 0;
    int gap_pct = 0;            // sender idle share, percent
    int stall_pct = 0;          // receiver stall share, percent
    int live_words = 0;         // words sent while a calibration was running

    // what the block last reported: drive for the motor model, phase for pacing
    logic signed [10:0] seen_drive = 0;
    logic [1:0]         seen_phase = PH_IDLE;

    logic [31:0] clk_ms, enc_pos;
    int          break_level;   // |drive| at which the simulated motor turns

    always #5 aclk = ~aclk;

    servo_stiction_duty_calibrator_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    ssdc_scoreboard u_scoreboard (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    // receiver back-pressure, redrawn every cycle
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // track what the block commands, the motor model reacts to it
    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            seen_drive <= m_tdata[10:0];
            seen_phase <= m_tdata[12:11];
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("servo_stiction_duty_calibrator_core: mismatch");
            $finish;
        end
    end

    // one word on the input channel; valid stays high into the next word unless a gap is drawn
    task automatic push_word(input bit start, input logic [31:0] now_ms, input logic [31:0] enc);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= {enc, now_ms};
        if (start || seen_phase == PH_BREAK || seen_phase == PH_HOLD) live_words++;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // register writes only once every expected word is back and the block had time to drain
    task automatic load_settings(input int vals [8]);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        for (int i = 0; i < 8; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= CFG_DATA_W'(vals[i]);
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        cfg_valid <= 1'b0;
    endtask

    // one tick: time moves, the motor turns when the drive is high enough
    task automatic send_tick();
        int r, m;
        r = $urandom_range(999);
        if (r < 30) clk_ms = clk_ms;
        else if (r < 40) clk_ms = clk_ms + $urandom_range(1, 99);
        else if (r < 45) clk_ms = clk_ms + $urandom_range(200, 2000);
        else clk_ms = clk_ms + $urandom_range(95, 140);
        m = (seen_drive < 0) ? -seen_drive : seen_drive;
        r = $urandom_range(99);
        if (r < 3) enc_pos = $urandom;
        else if (m >= break_level && m != 0)
            enc_pos = (seen_drive < 0) ? enc_pos - $urandom_range(1, 400)
                                       : enc_pos + $urandom_range(1, 400);
        else if (r < 20) enc_pos = enc_pos + $urandom_range(0, 2) - 1;
        push_word(1'b0, clk_ms, enc_pos);
    endtask

    // a whole calibration: start, ticks until done or idle, a forced timeout if it drags on
    task automatic run_calibration(input int lo, input int hi);
        int n;
        clk_ms = $urandom;
        enc_pos = $urandom;
        break_level = $urandom_range(lo, hi);
        push_word(1'b1, clk_ms, enc_pos);
        n = 0;
        // the first result is still in flight, so keep ticking a little before watching phase
        repeat (3) send_tick();
        while ((seen_phase == PH_BREAK || seen_phase == PH_HOLD) && n < 160) begin
            if ($urandom_range(199) == 0) push_word(1'b1, clk_ms, enc_pos);  // restart mid-run
            send_tick();
            n++;
        end
        if (n >= 160) begin
            clk_ms = clk_ms + TIMEOUT_MS + $urandom_range(1, 5000);
            push_word(1'b0, clk_ms, enc_pos);
        end
        repeat ($urandom_range(1, 3)) send_tick();   // ignored while idle or done
    endtask

    initial begin
        int vals [8];
        int mode;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tuser   <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_START_DUTY;
        cfg_data  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes of time and position, idle ticks, wrap, zero elapsed, timeout
        push_word(1'b0, 32'h0, 32'h0);
        push_word(1'b0, 32'hFFFF_FFFF, 32'h8000_0000);
        push_word(1'b1, 32'hFFFF_FF00, 32'h7FFF_FFFF);
        push_word(1'b0, 32'hFFFF_FF00, 32'h7FFF_FFFF);
        push_word(1'b0, 32'h0000_0064, 32'h8000_0010);
        push_word(1'b0, 32'h0000_0064, 32'h8000_0020);
        push_word(1'b0, 32'h0000_0300, 32'h8000_0500);
        push_word(1'b0, 32'h0000_0400, 32'h8000_0900);
        push_word(1'b0, 32'h0000_0500, 32'h8000_0D00);
        push_word(1'b0, 32'h0000_0600, 32'h8000_1100);
        push_word(1'b1, 32'h0000_0700, 32'h0000_0000);
        push_word(1'b0, 32'h0000_0900, 32'hFFFF_FFFF);
        push_word(1'b0, 32'h0000_0A00, 32'hFFFF_FF00);
        push_word(1'b0, 32'h0000_0A00 + TIMEOUT_MS + 1, 32'hFFFF_FF00);
        push_word(1'b0, 32'h0001_0000, 32'h1234_5678);
        push_word(1'b1, 32'h5555_5555, 32'hAAAA_AAAA);
        push_word(1'b0, 32'hAAAA_AAAA, 32'h5555_5555);

        // fixed settings first, extremes among them, then random ones
        for (int p = 0; live_words < WORD_TARGET; p++) begin
            case (p)
                0: vals = '{100, 1000, 100, 1, 1, 3, 200, 100};
                1: vals = '{0, 1000, 1000, 0, 0, 1, 0, 0};
                2: vals = '{1000, 1000, 1, 65535, 65535, 255, 65535, 65535};
                3: vals = '{200, 800, 150, 5, 20, 2, 300, 150};
                4: vals = '{0, 0, 1, 0, 0, 1, 0, 0};
                default: vals = '{$urandom_range(0, 300), $urandom_range(400, 1000),
                                  $urandom_range(60, 300), $urandom_range(0, 8),
                                  $urandom_range(0, 60), $urandom_range(1, 4),
                                  $urandom_range(0, 400), $urandom_range(0, 300)};
            endcase
            load_settings(vals);
            mode = p % 5;
            gap_pct   = (mode == 1) ? 46 : (mode == 3) ? 7 : 0;
            stall_pct = (mode == 2) ? 46 : (mode == 3) ? 7 : 0;
            if (mode == 4 && $urandom_range(1)) begin
                gap_pct = 46;
                stall_pct = 46;
            end
            run_calibration(0, vals[1] + 50);
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("servo_stiction_duty_calibrator_core: match");
        end else begin
            $display("servo_stiction_duty_calibrator_core: mismatch");
        end
        $finish;
    end

endmodule

[servo_stiction_duty_calibrator_core.f]
src/ssdc_pkg.sv
src/ssdc_cfg_regs.sv
src/ssdc_engine.sv
src/servo_stiction_duty_calibrator_core.sv
src/ssdc_checker.sv
bench/ssdc_scoreboard.sv
bench/servo_stiction_duty_calibrator_core_tb.sv
